// File: hw/rtl/spc_pkg.sv
// Package for the skin pixel classifier: pipeline latency, channel widths and
// the fixed coefficients of the skin color model.
// No dependencies.
`default_nettype none

package spc_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned LATENCY = 5;

  localparam logic [PIX_W-1:0] MASK_SKIN  = 8'hFF;
  localparam logic [PIX_W-1:0] MASK_OTHER = 8'h00;

  localparam logic [PIX_W:0]   RG_MIN_DIFF  = 9'd45;
  localparam logic [7:0]       WP_CH_COEF   = 8'd156;
  localparam logic [7:0]       WP_SUM_COEF  = 8'd52;
  localparam int unsigned      CIRCLE_SHIFT = 4;

  localparam logic [13:0] T_COEF        = 14'd10000;
  localparam logic [13:0] LO_RR_COEF    = 14'd7760;
  localparam logic [13:0] LO_RS_COEF    = 14'd5601;
  localparam logic [13:0] LO_SS_COEF    = 14'd1766;
  localparam logic [13:0] HI_RR_COEF    = 14'd13767;
  localparam logic [13:0] HI_RS_COEF    = 14'd10743;
  localparam logic [13:0] HI_SS_COEF    = 14'd1452;

endpackage

`default_nettype wire

// File: hw/rtl/spc_band.sv
// Quadratic band test of the skin classifier: 10000*G*S strictly between the
// lower and upper quadratics in R and S. Four register stages; uses spc_pkg.
`default_nettype none

module spc_band (
  input  wire logic                        clk,
  input  wire logic [spc_pkg::PIX_W-1:0]   green,
  input  wire logic [spc_pkg::PIX_W-1:0]   red,
  input  wire logic [spc_pkg::SUM_W-1:0]   sum,
  output logic                             in_band
);
  import spc_pkg::*;

  logic [15:0] rr_prod;
  logic [17:0] rs_prod;
  logic [17:0] gs_prod;
  logic [19:0] ss_prod;
  logic [15:0] rr;
  logic [17:0] rs;
  logic [17:0] gs;
  logic [19:0] ss;

  logic [31:0] t_prod, lrr_prod, lrs_prod, lss_prod, hrr_prod, hrs_prod, hss_prod;
  logic [31:0] t_val, lrr, lrs, lss, hrr, hrs, hss;

  logic signed [33:0] lower_next, upper_next;
  logic signed [33:0] lower, upper, t_dly;

  assign rr_prod = 16'(red) * 16'(red);
  assign rs_prod = 18'(red) * 18'(sum);
  assign gs_prod = 18'(green) * 18'(sum);
  assign ss_prod = 20'(sum) * 20'(sum);

  always_ff @(posedge clk) begin
    rr <= rr_prod;
    rs <= rs_prod;
    gs <= gs_prod;
    ss <= ss_prod;
  end

  assign t_prod   = 32'(gs) * 32'(T_COEF);
  assign lrr_prod = 32'(rr) * 32'(LO_RR_COEF);
  assign lrs_prod = 32'(rs) * 32'(LO_RS_COEF);
  assign lss_prod = 32'(ss) * 32'(LO_SS_COEF);
  assign hrr_prod = 32'(rr) * 32'(HI_RR_COEF);
  assign hrs_prod = 32'(rs) * 32'(HI_RS_COEF);
  assign hss_prod = 32'(ss) * 32'(HI_SS_COEF);

  always_ff @(posedge clk) begin
    t_val <= t_prod;
    lrr   <= lrr_prod;
    lrs   <= lrs_prod;
    lss   <= lss_prod;
    hrr   <= hrr_prod;
    hrs   <= hrs_prod;
    hss   <= hss_prod;
  end

  assign lower_next = $signed({2'b00, lrs}) + $signed({2'b00, lss}) - $signed({2'b00, lrr});
  assign upper_next = $signed({2'b00, hrs}) + $signed({2'b00, hss}) - $signed({2'b00, hrr});

  always_ff @(posedge clk) begin
    lower <= lower_next;
    upper <= upper_next;
    t_dly <= $signed({2'b00, t_val});
  end

  always_ff @(posedge clk) begin
    in_band <= (t_dly > lower) && (t_dly < upper);
  end

endmodule

`default_nettype wire

// File: hw/rtl/skin_pixel_classifier_core.sv
// Top level of the skin pixel classifier: a five-stage pipeline that turns a
// blue, green, red pixel into a skin mask byte. Uses spc_pkg and spc_band.
//
// Usage:
//   A pixel is taken at a rising edge where start is high and busy is low.
//   busy is always low, so a new pixel may be given in every cycle.
//   Each transaction yields exactly one result: mask is valid while done is
//   high, for one cycle, once the pixel has passed through all register stages. Results
//   come out in the order the pixels went in.
//   mask is 8'hFF for a skin pixel and 8'h00 otherwise.
//   Throughput is one pixel per clock; the latency is set by the five register
//   stages: channel sums, products, constant scaling, quadratic sums, and the
//   final compare.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Synchronous reset clears the valid bits of all stages, so no done pulse
//   follows reset until a new pixel is taken. The data registers are not reset.
`default_nettype none

module skin_pixel_classifier_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [spc_pkg::PIX_W-1:0]   blue,
  input  wire logic [spc_pkg::PIX_W-1:0]   green,
  input  wire logic [spc_pkg::PIX_W-1:0]   red,
  output logic                             done,
  output logic [spc_pkg::PIX_W-1:0]        mask
);
  import spc_pkg::*;

  logic [LATENCY-1:0] valid;

  logic [SUM_W-1:0]   sum_next;
  logic signed [17:0] dr_next, dg_next;

  logic [PIX_W-1:0]   g1, r1;
  logic [SUM_W-1:0]   s1;
  logic signed [17:0] dr1, dg1;
  logic               rg_ok1, gb_ok1;

  logic signed [35:0] dr_prod, dg_prod;
  logic [19:0]        ss_prod;
  logic [30:0]        dr_sq, dg_sq;
  logic [19:0]        ss2;
  logic               rg_ok2, gb_ok2;

  logic [31:0]        dist_sum;
  logic               pass3, pass4, pass5;
  logic               in_band;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LATENCY-2:0], start & ~busy};
    end
  end

  assign sum_next = SUM_W'(blue) + SUM_W'(green) + SUM_W'(red);
  assign dr_next  = $signed(18'(red) * 18'(WP_CH_COEF)) - $signed(18'(sum_next) * 18'(WP_SUM_COEF));
  assign dg_next  = $signed(18'(green) * 18'(WP_CH_COEF))
                  - $signed(18'(sum_next) * 18'(WP_SUM_COEF));

  always_ff @(posedge clk) begin
    g1     <= green;
    r1     <= red;
    s1     <= sum_next;
    dr1    <= dr_next;
    dg1    <= dg_next;
    rg_ok1 <= {1'b0, red} >= ({1'b0, green} + RG_MIN_DIFF);
    gb_ok1 <= green > blue;
  end

  assign dr_prod = 36'(dr1) * 36'(dr1);
  assign dg_prod = 36'(dg1) * 36'(dg1);
  assign ss_prod = 20'(s1) * 20'(s1);

  always_ff @(posedge clk) begin
    dr_sq  <= dr_prod[30:0];
    dg_sq  <= dg_prod[30:0];
    ss2    <= ss_prod;
    rg_ok2 <= rg_ok1;
    gb_ok2 <= gb_ok1;
  end

  assign dist_sum = {1'b0, dr_sq} + {1'b0, dg_sq};

  always_ff @(posedge clk) begin
    pass3 <= rg_ok2 && gb_ok2 && (dist_sum >= 32'(ss2 >> CIRCLE_SHIFT));
    pass4 <= pass3;
    pass5 <= pass4;
  end

  spc_band u_band (
    .clk     (clk),
    .green   (g1),
    .red     (r1),
    .sum     (s1),
    .in_band (in_band)
  );

  assign done = valid[LATENCY-1];
  assign mask = (pass5 && in_band) ? MASK_SKIN : MASK_OTHER;

endmodule

`default_nettype wire

// File: hw/rtl/spc_checker.sv
// Port-level checks for the skin pixel classifier core, and the bind that
// attaches them to it. Uses spc_pkg.
`default_nettype none

module spc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [spc_pkg::PIX_W-1:0]   green,
  input wire logic [spc_pkg::PIX_W-1:0]   red,
  input wire logic                        done,
  input wire logic [spc_pkg::PIX_W-1:0]   mask
);
  import spc_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 done)
    else $error("accepted transaction gave no result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without a matching accepted transaction");

  a_mask_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (mask == MASK_SKIN) || (mask == MASK_OTHER))
    else $error("mask is neither the skin nor the non-skin code");

  a_red_not_above: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (red <= green) |-> ##5 (mask == MASK_OTHER))
    else $error("pixel with red not above green was marked as skin");

endmodule

bind skin_pixel_classifier_core spc_checker u_spc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .green (green),
  .red   (red),
  .done  (done),
  .mask  (mask)
);

`default_nettype wire
